// ===== rtl/core/rgb_to_hsl_pixel_assert.svh =====
// ----------------------------------------------------------------------------
// rgb to hsl assertion macros
// shared forms for the concurrent checks of the pixel converter
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_PIXEL_ASSERT_SVH
`define RGB_TO_HSL_PIXEL_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RTHSL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RTHSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rthsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rthsl_pkg
// types and constants shared by the rgb to hsl pixel converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rthsl_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned LightW  = 9;
  localparam int unsigned FracW   = 16;
  localparam int unsigned SatDenW = 8;
  localparam int unsigned HueDenW = 11;
  localparam int unsigned NumCells = FracW;

  localparam logic [LightW-1:0] FullSum = 9'd510;
  localparam logic [FracW-1:0]  FracMax = 16'hFFFF;

  // one word in flight through the divider row
  typedef struct packed {
    logic                vld;
    logic                gray;
    logic                sat_full;
    logic [LightW-1:0]   light;
    logic [SatDenW-1:0]  sat_den;
    logic [SatDenW-1:0]  sat_rem;
    logic [FracW-1:0]    sat_q;
    logic [HueDenW-1:0]  hue_den;
    logic [HueDenW-1:0]  hue_rem;
    logic [FracW-1:0]    hue_q;
  } rthsl_cell_t;

endpackage

// ===== rtl/core/rgb_to_hsl_pixel.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel
// rgb pixel to hue, saturation and lightness through a row of divider cells
//
//   channel  direction  fields                                   handshake
//   in_      input      red_level, green_level, blue_level       valid / stall
//   out_     output     hue_turn, saturation_frac, lightness_sum valid / stall
//
// one word accepted per cycle while the output is not held back
// the row is the front cell plus sixteen division cells, one bit each
// the whole row holds in place while a finished word waits under out_stall
// synchronous active-low reset clears the valid bits of every cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rgb_to_hsl_pixel_assert.svh"

module rgb_to_hsl_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red_level,
  input  logic [7:0]  in_green_level,
  input  logic [7:0]  in_blue_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_hue_turn,
  output logic [15:0] out_saturation_frac,
  output logic [8:0]  out_lightness_sum
);
  import rthsl_pkg::*;

  rthsl_cell_t chain [NumCells+1];
  rthsl_cell_t last;
  logic        adv;

  assign last     = chain[NumCells];
  assign adv      = !(last.vld && out_stall);
  assign in_stall = !adv;

  rthsl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .vld_i   (in_valid),
    .red_i   (in_red_level),
    .green_i (in_green_level),
    .blue_i  (in_blue_level),
    .cell_o  (chain[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    rthsl_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  assign out_valid           = last.vld;
  assign out_lightness_sum   = last.light;
  assign out_hue_turn        = last.gray ? '0 : last.hue_q;
  assign out_saturation_frac = last.gray ? '0 : (last.sat_full ? FracMax : last.sat_q);

  `RTHSL_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, chain[0].vld, "accepted word lost at front")
  `RTHSL_ASSERT_IMPL(a_hue_rem_bound, chain[0].vld && !chain[0].gray, chain[0].hue_rem < chain[0].hue_den, "hue numerator not below divisor")
  `RTHSL_ASSERT_IMPL(a_sat_rem_bound, chain[0].vld && !chain[0].gray && !chain[0].sat_full, chain[0].sat_rem < chain[0].sat_den, "saturation numerator not below divisor")
  `RTHSL_ASSERT_IMPL(a_zero_sat_gray, out_valid && out_saturation_frac == '0, out_hue_turn == '0 && !out_lightness_sum[0], "zero saturation on a non-gray word")

endmodule

// ===== rtl/core/rthsl_front.sv =====
// ----------------------------------------------------------------------------
// rthsl_front
// first cell: extremes, lightness, divisors and numerators of a pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rthsl_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       vld_i,
  input  logic [7:0]                 red_i,
  input  logic [7:0]                 green_i,
  input  logic [7:0]                 blue_i,
  output rthsl_pkg::rthsl_cell_t     cell_o
);
  import rthsl_pkg::*;

  rthsl_cell_t cell_r, cell_nxt;

  logic [ChanW-1:0]   mx, mn, c;
  logic [LightW-1:0]  sum, rsum;
  logic [HueDenW-1:0] c_w, two_c, four_c, six_c, n;
  logic [HueDenW-1:0] r_w, g_w, b_w;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i  > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i  < mn) mn = blue_i;
    c    = mx - mn;
    sum  = {1'b0, mx} + {1'b0, mn};
    rsum = FullSum - sum;

    c_w    = {3'b000, c};
    two_c  = {c_w[HueDenW-2:0], 1'b0};
    four_c = {c_w[HueDenW-3:0], 2'b00};
    six_c  = four_c + two_c;
    r_w    = {3'b000, red_i};
    g_w    = {3'b000, green_i};
    b_w    = {3'b000, blue_i};

    // sector order red, green, blue on ties
    if (red_i == mx) begin
      if (green_i >= blue_i) n = g_w - b_w;
      else                   n = six_c - (b_w - g_w);
    end else if (green_i == mx) begin
      n = two_c + b_w - r_w;
    end else begin
      n = four_c + r_w - g_w;
    end

    cell_nxt          = '0;
    cell_nxt.vld      = vld_i;
    cell_nxt.gray     = (c == '0);
    cell_nxt.light    = sum;
    cell_nxt.sat_den  = (sum < rsum) ? sum[SatDenW-1:0] : rsum[SatDenW-1:0];
    cell_nxt.sat_full = ({1'b0, c} == ((sum < rsum) ? sum : rsum));
    cell_nxt.sat_rem  = c;
    cell_nxt.hue_den  = six_c;
    cell_nxt.hue_rem  = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (adv) begin
      cell_r.vld <= cell_nxt.vld;
    end
    if (adv) begin
      cell_r.gray     <= cell_nxt.gray;
      cell_r.sat_full <= cell_nxt.sat_full;
      cell_r.light    <= cell_nxt.light;
      cell_r.sat_den  <= cell_nxt.sat_den;
      cell_r.sat_rem  <= cell_nxt.sat_rem;
      cell_r.sat_q    <= cell_nxt.sat_q;
      cell_r.hue_den  <= cell_nxt.hue_den;
      cell_r.hue_rem  <= cell_nxt.hue_rem;
      cell_r.hue_q    <= cell_nxt.hue_q;
    end
  end

  assign cell_o = cell_r;

endmodule

// ===== rtl/core/rthsl_div_cell.sv =====
// ----------------------------------------------------------------------------
// rthsl_div_cell
// one restoring step of both fraction divisions, one quotient bit each
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rthsl_div_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  rthsl_pkg::rthsl_cell_t     cell_i,
  output rthsl_pkg::rthsl_cell_t     cell_o
);
  import rthsl_pkg::*;

  rthsl_cell_t cell_r, cell_nxt;

  logic [SatDenW:0] sat_t;
  logic [HueDenW:0] hue_t;
  logic             sat_ge, hue_ge;
  logic [SatDenW:0] sat_d;
  logic [HueDenW:0] hue_d;

  always_comb begin
    sat_t  = {cell_i.sat_rem, 1'b0};
    hue_t  = {cell_i.hue_rem, 1'b0};
    sat_ge = (sat_t >= {1'b0, cell_i.sat_den});
    hue_ge = (hue_t >= {1'b0, cell_i.hue_den});
    sat_d  = sat_t - {1'b0, cell_i.sat_den};
    hue_d  = hue_t - {1'b0, cell_i.hue_den};

    cell_nxt         = cell_i;
    cell_nxt.sat_rem = sat_ge ? sat_d[SatDenW-1:0] : sat_t[SatDenW-1:0];
    cell_nxt.hue_rem = hue_ge ? hue_d[HueDenW-1:0] : hue_t[HueDenW-1:0];
    cell_nxt.sat_q   = {cell_i.sat_q[FracW-2:0], sat_ge};
    cell_nxt.hue_q   = {cell_i.hue_q[FracW-2:0], hue_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (adv) begin
      cell_r.vld <= cell_nxt.vld;
    end
    if (adv) begin
      cell_r.gray     <= cell_nxt.gray;
      cell_r.sat_full <= cell_nxt.sat_full;
      cell_r.light    <= cell_nxt.light;
      cell_r.sat_den  <= cell_nxt.sat_den;
      cell_r.sat_rem  <= cell_nxt.sat_rem;
      cell_r.sat_q    <= cell_nxt.sat_q;
      cell_r.hue_den  <= cell_nxt.hue_den;
      cell_r.hue_rem  <= cell_nxt.hue_rem;
      cell_r.hue_q    <= cell_nxt.hue_q;
    end
  end

  assign cell_o = cell_r;

endmodule

// ===== dv/tb_rgb_to_hsl_pixel.sv =====
// ----------------------------------------------------------------------------
// tb_rgb_to_hsl_pixel
// self-checking bench for the rgb to hsl pixel converter: directed corner
// pixels then random ones, both sides idling at random, every output word
// compared field by field against an in-bench hue, saturation and lightness
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rgb_to_hsl_pixel;

  import rthsl_pkg::*;

  localparam int RandomPixels = 1700;
  localparam int QuietLimit   = 2000;
  localparam int DrainCycles  = 40;
  localparam int IdlePct      = 29;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [FracW-1:0]  hue;
    logic [FracW-1:0]  sat;
    logic [LightW-1:0] light;
  } hsl_t;

  class hsl_scoreboard;
    hsl_t pending[$];
    int   fails;

    function new();
      fails = 0;
    endfunction

    function hsl_t predict_hsl(rgb_t px);
      int   r, g, b, mx, mn, c, sum, den, n, q;
      hsl_t res;
      r = px.r;
      g = px.g;
      b = px.b;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c = mx - mn;
      sum = mx + mn;
      res.light = LightW'(sum);
      res.hue = '0;
      res.sat = '0;
      if (c != 0) begin
        den = (sum < int'(FullSum) - sum) ? sum : int'(FullSum) - sum;
        q = (c * 65536) / den;
        res.sat = (q > int'(FracMax)) ? FracMax : FracW'(q);
        // sector order: red, then green, then blue on ties
        if (r == mx) begin
          n = g - b;
        end else if (g == mx) begin
          n = 2 * c + b - r;
        end else begin
          n = 4 * c + r - g;
        end
        if (n < 0) n = n + 6 * c;
        q = (n * 65536) / (6 * c);
        res.hue = (q > int'(FracMax)) ? FracMax : FracW'(q);
      end
      return res;
    endfunction

    function void note_pixel(rgb_t px);
      pending.push_back(predict_hsl(px));
    endfunction

    function void check_word(hsl_t got);
      hsl_t want;
      if (pending.size() == 0) begin
        $error("unexpected output word: hue %0d sat %0d light %0d",
               got.hue, got.sat, got.light);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (got.hue !== want.hue) begin
        $error("hue_turn mismatch: expected %0d, actual %0d", want.hue, got.hue);
        fails++;
      end
      if (got.sat !== want.sat) begin
        $error("saturation_frac mismatch: expected %0d, actual %0d", want.sat, got.sat);
        fails++;
      end
      if (got.light !== want.light) begin
        $error("lightness_sum mismatch: expected %0d, actual %0d", want.light, got.light);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_red_level = '0;
  logic [7:0]  in_green_level = '0;
  logic [7:0]  in_blue_level = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_hue_turn;
  logic [15:0] out_saturation_frac;
  logic [8:0]  out_lightness_sum;

  hsl_scoreboard sb;
  rgb_t          pixel_q[$];
  int            total_pixels = 0;
  int            sent = 0;
  int            quiet = 0;
  logic          burst;

  rgb_to_hsl_pixel dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_red_level        (in_red_level),
    .in_green_level      (in_green_level),
    .in_blue_level       (in_blue_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hue_turn        (out_hue_turn),
    .out_saturation_frac (out_saturation_frac),
    .out_lightness_sum   (out_lightness_sum)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // stretch with no idling on either side
  assign burst = (sent >= 700) && (sent < 1000);

  task automatic add_pixel(input int r, input int g, input int b);
    rgb_t px;
    px.r = 8'(r);
    px.g = 8'(g);
    px.b = 8'(b);
    pixel_q.push_back(px);
  endtask

  function automatic int edge_level();
    case ($urandom_range(3))
      0: return 0;
      1: return 1;
      2: return 254;
      default: return 255;
    endcase
  endfunction

  task automatic add_random_pixel();
    int kind, v, w;
    kind = $urandom_range(99);
    v = $urandom_range(255);
    w = $urandom_range(255);
    if (kind < 70) begin
      add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    end else if (kind < 78) begin
      add_pixel(v, v, v);
    end else if (kind < 90) begin
      // two channels tied
      case ($urandom_range(2))
        0: add_pixel(v, v, w);
        1: add_pixel(v, w, v);
        default: add_pixel(w, v, v);
      endcase
    end else begin
      add_pixel(edge_level(), edge_level(), edge_level());
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rgb_t px;
        px.r = in_red_level;
        px.g = in_green_level;
        px.b = in_blue_level;
        sb.note_pixel(px);
        sent <= sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() > 0 && (burst || $urandom_range(99) >= IdlePct)) begin
          rgb_t nx;
          nx = pixel_q.pop_front();
          in_red_level <= nx.r;
          in_green_level <= nx.g;
          in_blue_level <= nx.b;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        hsl_t got;
        got.hue = out_hue_turn;
        got.sat = out_saturation_frac;
        got.light = out_lightness_sum;
        sb.check_word(got);
      end
      out_stall <= !burst && ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QuietLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    // gray pixels
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(128, 128, 128);
    // primaries and secondaries, full saturation
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    // hue just below a full turn
    add_pixel(255, 0, 1);
    add_pixel(1, 0, 1);
    // divisor of one
    add_pixel(1, 0, 0);
    add_pixel(0, 1, 1);
    add_pixel(254, 255, 255);
    add_pixel(255, 254, 254);
    add_pixel(0, 0, 1);
    // each sector, ordinary values
    add_pixel(200, 100, 50);
    add_pixel(30, 220, 90);
    add_pixel(70, 40, 180);
    add_pixel(10, 20, 30);
    add_pixel(128, 127, 127);
    add_pixel(127, 128, 128);
    for (int i = 0; i < RandomPixels; i++) begin
      add_random_pixel();
    end
    total_pixels = pixel_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (!(sent == total_pixels && sb.pending.size() == 0)) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
